// ===== sv/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, codes and helpers of the vertex normal averager.
// ----------------------------------------------------------------------------
package vna_pkg;

	localparam int VERTEX_SLOTS_DEF = 64;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_TRI   = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic signed [24:0] ACC_MAX = 25'sd8388607;
	localparam logic signed [24:0] ACC_MIN = -25'sd8388608;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_RA,
		ST_RB,
		ST_RC,
		ST_RE,
		ST_XMUL,
		ST_RACC,
		ST_ACCD,
		ST_ABS,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_ADDR,
		ST_ADDW,
		ST_OUT
	} st_t;

	// saturating accumulator add
	function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
			input logic signed [15:0] b);
		logic signed [24:0] s;
		s = 25'(a) + 25'(b);
		if (s > ACC_MAX) begin
			return ACC_MAX[23:0];
		end else if (s < ACC_MIN) begin
			return ACC_MIN[23:0];
		end
		return s[23:0];
	endfunction

endpackage

// ===== sv/vna_mul.sv =====
// ----------------------------------------------------------------------------
// vna_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module vna_mul import vna_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== sv/vna_isqrt.sv =====
// ----------------------------------------------------------------------------
// vna_isqrt
// Integer square root of a 62-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vna_isqrt import vna_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [61:0] s,
	output logic [31:0] root,
	output logic        done_q
);

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign root  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, s};
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ===== sv/vna_div.sv =====
// ----------------------------------------------------------------------------
// vna_div
// Restoring divider for a 15-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vna_div import vna_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [44:0] num,
	input  logic [31:0] den,
	output logic [14:0] quo_q,
	output logic        done_q
);

	logic [32:0] rem_q;
	logic [14:0] low_q;
	logic [31:0] den_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic [32:0] t;

	assign t = {rem_q[31:0], low_q[14]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 4'd14) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient fits 15 bits, so the top part is already below den
			rem_q <= {3'b000, num[44:15]};
			low_q <= num[14:0];
			den_q <= den;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (t >= {1'b0, den_q}) begin
				rem_q <= t - {1'b0, den_q};
				quo_q <= {quo_q[13:0], 1'b1};
			end else begin
				rem_q <= t;
				quo_q <= {quo_q[13:0], 1'b0};
			end
			low_q <= {low_q[13:0], 1'b0};
			cnt_q <= cnt_q + 4'd1;
		end
	end

endmodule

// ===== sv/vertex_normal_averager_top.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_averager_top
// Per-vertex normal averaging for a triangle mesh, Q8.8 in, Q1.14 out.
// ----------------------------------------------------------------------------
// After reset the block sweeps the accumulator memory, one vertex a cycle,
// before it takes its first item. A position write is done in its accept
// cycle. After its accept cycle a triangle reads the positions, forms the
// cross product on the shared multiplier, takes magnitudes, shifts them to
// normalize, squares them, runs the bit-serial square root and then the
// bit-serial divider once per component, and makes the three accumulator
// updates; a zero-area triangle stops after the shift. A normal read reads
// the accumulator and takes the same steps from the magnitudes through the
// divider, going straight to the output after the shift for a zero
// accumulator, plus any wait on the output.
module vertex_normal_averager_top import vna_pkg::*; #(
	parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [5:0]         vertex_index,
	input  logic [5:0]         corner_b,
	input  logic [5:0]         corner_c,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               degenerate
);

	localparam int AW = $clog2(VERTEX_SLOTS);
	localparam logic [16:0] SLOTS_W = 17'(VERTEX_SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(VERTEX_SLOTS - 1);

	st_t state_q, state_d;

	logic [47:0] pos_mem [VERTEX_SLOTS];
	logic [71:0] acc_mem [VERTEX_SLOTS];
	logic [47:0] pos_rd_q;
	logic [71:0] acc_rd_q;

	logic          pos_we, acc_we;
	logic [AW-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
	logic [47:0]   pos_wdata;
	logic [71:0]   acc_wdata;

	logic [AW-1:0] clr_q;
	logic          tri_q;
	logic [AW-1:0] idx_q [3];
	logic [2:0]    step_q;
	logic [1:0]    sel_q;

	logic signed [15:0] pa_q [3];
	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [35:0] c_q  [3];
	logic [35:0]        mag_q [3];
	logic [2:0]         neg_q;
	logic [35:0]        m_q;
	logic [61:0]        sum_q;
	logic [31:0]        root_q;
	logic signed [15:0] n_q [3];
	logic               degen_q;

	logic signed [15:0] out_x_q, out_y_q, out_z_q;
	logic               out_degen_q, out_valid_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic               sq_start, dv_start, sq_done, dv_done;
	logic [31:0]        sq_root;
	logic [44:0]        dv_num;
	logic [14:0]        dv_quo;

	logic [16:0]   ia_w, ib_w, ic_w;
	logic          ia_ok, all_ok, accept, out_free;
	logic [47:0]   pos_in;
	logic signed [16:0] pos_rd [3];

	assign ia_w   = {11'd0, vertex_index};
	assign ib_w   = {11'd0, corner_b};
	assign ic_w   = {11'd0, corner_c};
	assign ia_ok  = ia_w < SLOTS_W;
	assign all_ok = ia_ok && (ib_w < SLOTS_W) && (ic_w < SLOTS_W);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign pos_in = {pos_z, pos_y, pos_x};

	assign pos_rd[0] = 17'(signed'(pos_rd_q[15:0]));
	assign pos_rd[1] = 17'(signed'(pos_rd_q[31:16]));
	assign pos_rd[2] = 17'(signed'(pos_rd_q[47:32]));

	assign in_ready   = state_q == ST_IDLE;
	assign out_valid  = out_valid_q;
	assign normal_x   = out_x_q;
	assign normal_y   = out_y_q;
	assign normal_z   = out_z_q;
	assign degenerate = out_degen_q;

	vna_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	vna_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.s      (sum_q),
		.root   (sq_root),
		.done_q (sq_done)
	);

	vna_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (root_q),
		.quo_q  (dv_quo),
		.done_q (dv_done)
	);

	// memories
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[acc_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == LAST_SLOT) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_TRI && all_ok) begin
						state_d = ST_RA;
					end else if (mode == MODE_READ) begin
						state_d = ia_ok ? ST_RACC : ST_OUT;
					end
				end
			end
			ST_RA:    state_d = ST_RB;
			ST_RB:    state_d = ST_RC;
			ST_RC:    state_d = ST_RE;
			ST_RE:    state_d = ST_XMUL;
			ST_XMUL: begin
				if (step_q == 3'd6) state_d = ST_ABS;
			end
			ST_RACC:  state_d = ST_ACCD;
			ST_ACCD:  state_d = ST_ABS;
			ST_ABS:   state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (m_q == '0) begin
					state_d = tri_q ? ST_IDLE : ST_OUT;
				end else if (m_q[35:29] == 7'd1) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (step_q == 3'd3) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sq_done) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (dv_done && sel_q == 2'd2) state_d = tri_q ? ST_ADDR : ST_OUT;
			end
			ST_ADDR:  state_d = ST_ADDW;
			ST_ADDW: begin
				state_d = (sel_q == 2'd2) ? ST_IDLE : ST_ADDR;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		pos_we    = 1'b0;
		pos_waddr = ia_w[AW-1:0];
		pos_wdata = pos_in;
		pos_raddr = '0;
		acc_we    = 1'b0;
		acc_waddr = ia_w[AW-1:0];
		acc_wdata = '0;
		acc_raddr = '0;
		mul_a     = '0;
		mul_b     = '0;
		sq_start  = 1'b0;
		dv_start  = 1'b0;
		dv_num    = {1'b0, mag_q[sel_q][29:0], 14'd0} + {14'd0, root_q[31:1]};
		case (state_q)
			ST_CLR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
			end
			ST_IDLE: begin
				if (accept && mode == MODE_WRITE && ia_ok) begin
					pos_we = 1'b1;
					acc_we = 1'b1;
				end
			end
			ST_RA:   pos_raddr = idx_q[0];
			ST_RB:   pos_raddr = idx_q[1];
			ST_RC:   pos_raddr = idx_q[2];
			ST_RACC: acc_raddr = idx_q[0];
			ST_XMUL: begin
				// cross product terms in the order y*z, z*y, z*x, x*z, x*y, y*x
				case (step_q)
					3'd0: begin mul_a = 32'(e1_q[1]); mul_b = 32'(e2_q[2]); end
					3'd1: begin mul_a = 32'(e1_q[2]); mul_b = 32'(e2_q[1]); end
					3'd2: begin mul_a = 32'(e1_q[2]); mul_b = 32'(e2_q[0]); end
					3'd3: begin mul_a = 32'(e1_q[0]); mul_b = 32'(e2_q[2]); end
					3'd4: begin mul_a = 32'(e1_q[0]); mul_b = 32'(e2_q[1]); end
					3'd5: begin mul_a = 32'(e1_q[1]); mul_b = 32'(e2_q[0]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_SQ: begin
				if (step_q < 3'd3) begin
					mul_a = {2'b00, mag_q[step_q[1:0]][29:0]};
					mul_b = {2'b00, mag_q[step_q[1:0]][29:0]};
				end
			end
			ST_SQRT: sq_start = step_q == 3'd0;
			ST_DIV:  dv_start = step_q == 3'd0;
			ST_ADDR: acc_raddr = idx_q[sel_q];
			ST_ADDW: begin
				acc_we    = 1'b1;
				acc_waddr = idx_q[sel_q];
				acc_wdata = {sat_add(acc_rd_q[71:48], n_q[2]),
					sat_add(acc_rd_q[47:24], n_q[1]),
					sat_add(acc_rd_q[23:0], n_q[0])};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tri_q    <= mode == MODE_TRI;
				idx_q[0] <= ia_w[AW-1:0];
				idx_q[1] <= ib_w[AW-1:0];
				idx_q[2] <= ic_w[AW-1:0];
				degen_q  <= 1'b1;
				step_q   <= '0;
				sel_q    <= '0;
				for (int i = 0; i < 3; i++) n_q[i] <= '0;
			end
			ST_RB: begin
				for (int i = 0; i < 3; i++) pa_q[i] <= pos_rd_q[16*i +: 16];
			end
			ST_RC: begin
				for (int i = 0; i < 3; i++) e1_q[i] <= pos_rd[i] - 17'(pa_q[i]);
			end
			ST_RE: begin
				for (int i = 0; i < 3; i++) e2_q[i] <= pos_rd[i] - 17'(pa_q[i]);
			end
			ST_XMUL: begin
				step_q <= step_q + 3'd1;
				if (step_q != 3'd0) begin
					if (step_q[0]) begin
						c_q[step_q[2:1]] <= mul_p[35:0];
					end else begin
						c_q[step_q[2:1] - 2'd1] <= c_q[step_q[2:1] - 2'd1] - mul_p[35:0];
					end
				end
			end
			ST_ACCD: begin
				c_q[0] <= 36'(signed'(acc_rd_q[23:0]));
				c_q[1] <= 36'(signed'(acc_rd_q[47:24]));
				c_q[2] <= 36'(signed'(acc_rd_q[71:48]));
			end
			ST_ABS: begin
				logic [35:0] a0, a1, a2, mx;
				a0 = c_q[0][35] ? 36'(-c_q[0]) : 36'(c_q[0]);
				a1 = c_q[1][35] ? 36'(-c_q[1]) : 36'(c_q[1]);
				a2 = c_q[2][35] ? 36'(-c_q[2]) : 36'(c_q[2]);
				mx = (a0 > a1) ? a0 : a1;
				if (a2 > mx) mx = a2;
				mag_q[0] <= a0;
				mag_q[1] <= a1;
				mag_q[2] <= a2;
				neg_q    <= {c_q[2][35], c_q[1][35], c_q[0][35]};
				m_q      <= mx;
				sum_q    <= '0;
				step_q   <= '0;
			end
			ST_SHIFT: begin
				// bring the largest magnitude into [2^29, 2^30)
				if (m_q != '0 && m_q[35:29] == 7'd0) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
				end else if (m_q[35:30] != 6'd0) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end
			end
			ST_SQ: begin
				if (step_q == 3'd3) begin
					step_q <= '0;
				end else begin
					step_q <= step_q + 3'd1;
				end
				if (step_q != 3'd0) sum_q <= sum_q + mul_p[61:0];
			end
			ST_SQRT: begin
				step_q <= 3'd1;
				if (sq_done) begin
					root_q <= sq_root;
					step_q <= '0;
				end
			end
			ST_DIV: begin
				step_q <= 3'd1;
				if (dv_done) begin
					n_q[sel_q] <= neg_q[sel_q] ? -16'(dv_quo) : 16'(dv_quo);
					step_q     <= '0;
					degen_q    <= 1'b0;
					sel_q      <= (sel_q == 2'd2) ? 2'd0 : sel_q + 2'd1;
				end
			end
			ST_ADDW: begin
				sel_q <= sel_q + 2'd1;
			end
			ST_OUT: begin
				if (out_free) begin
					out_x_q     <= n_q[0];
					out_y_q     <= n_q[1];
					out_z_q     <= n_q[2];
					out_degen_q <= degen_q;
				end
			end
			default: ;
		endcase
	end

endmodule
